// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/clis_pkg.sv
// Package: phase codes, opcodes and cycle-count table for the load sequencer
package clis_pkg;
    typedef enum logic [5:0] {
        PH_START   = 6'b000001,
        PH_OPCODE  = 6'b000010,
        PH_IMM1    = 6'b000100,
        PH_IMM2    = 6'b001000,
        PH_MEMREAD = 6'b010000,
        PH_WDONE   = 6'b100000
    } t_phase;

    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_HALT    = 8'h76;
    localparam logic [7:0] OP_LD_HLN  = 8'h36;
    localparam logic [7:0] OP_LD_ABC  = 8'h0A;
    localparam logic [7:0] OP_LD_ADE  = 8'h1A;
    localparam logic [7:0] OP_LD_AHLI = 8'h2A;
    localparam logic [7:0] OP_LD_AHLD = 8'h3A;
    localparam logic [7:0] OP_LD_BCA  = 8'h02;
    localparam logic [7:0] OP_LD_DEA  = 8'h12;
    localparam logic [7:0] OP_LD_HLIA = 8'h22;
    localparam logic [7:0] OP_LD_HLDA = 8'h32;
    localparam logic [7:0] OP_LDH_CA  = 8'hE2;
    localparam logic [7:0] OP_LDH_AC  = 8'hF2;
    localparam logic [7:0] OP_LD_SPHL = 8'hF9;
    localparam logic [7:0] OP_LD_ANN  = 8'hFA;
    localparam logic [7:0] OP_LD_NNA  = 8'hEA;
    localparam logic [7:0] OP_LDH_NA  = 8'hE0;
    localparam logic [7:0] OP_LDH_AN  = 8'hF0;
    localparam logic [7:0] OP_LD_HLSP = 8'hF8;
    localparam logic [7:0] OP_LD_BCNN = 8'h01;
    localparam logic [7:0] OP_LD_DENN = 8'h11;
    localparam logic [7:0] OP_LD_HLNN = 8'h21;
    localparam logic [7:0] OP_LD_SPNN = 8'h31;

    localparam logic [2:0] R_B = 3'd0;
    localparam logic [2:0] R_C = 3'd1;
    localparam logic [2:0] R_D = 3'd2;
    localparam logic [2:0] R_E = 3'd3;
    localparam logic [2:0] R_H = 3'd4;
    localparam logic [2:0] R_L = 3'd5;
    localparam logic [2:0] R_M = 3'd6;
    localparam logic [2:0] R_A = 3'd7;

    localparam logic [15:0] HIGH_PAGE = 16'hFF00;

    // Register-to-register group, excluding HALT
    function automatic logic is_ldrr(input logic [7:0] op);
        return (op[7:6] == 2'b01) && (op != OP_HALT);
    endfunction

    // LD r,n group including LD (HL),n
    function automatic logic is_ldrn(input logic [7:0] op);
        return (op & 8'hC7) == 8'h06;
    endfunction

    // Total clock cycles of an instruction
    function automatic logic [4:0] cycles_of(input logic [7:0] op);
        logic [4:0] c;
        if (is_ldrr(op)) begin
            c = (op[2:0] == R_M || op[5:3] == R_M) ? 5'd8 : 5'd4;
        end else if (is_ldrn(op)) begin
            c = (op == OP_LD_HLN) ? 5'd12 : 5'd8;
        end else begin
            case (op)
                OP_LD_ABC, OP_LD_ADE, OP_LD_AHLI, OP_LD_AHLD,
                OP_LD_BCA, OP_LD_DEA, OP_LD_HLIA, OP_LD_HLDA,
                OP_LDH_CA, OP_LDH_AC, OP_LD_SPHL: c = 5'd8;
                OP_LD_ANN, OP_LD_NNA: c = 5'd16;
                OP_LDH_NA, OP_LDH_AN, OP_LD_HLSP,
                OP_LD_BCNN, OP_LD_DENN, OP_LD_HLNN, OP_LD_SPNN: c = 5'd12;
                default: c = 5'd4;
            endcase
        end
        return c;
    endfunction
endpackage

// File: hw/rtl/cpu_load_instruction_sequencer.sv
// Top level: load-instruction sequencer driven by completed bus cycles
//
// Input channel: one transaction per completed bus cycle, carrying the byte
// read by the previous request (ignored after a write and on the first
// transaction after reset). Output channel: one transaction per input, the
// next bus request (address, write flag, write data), with an opcode-fetch
// mark plus the cycle count and unknown flag of the finished instruction.
// The register file, PC, SP, phase and latches are updated in one pass of
// combinational logic from the accepted input; the request is captured in an
// output register at acceptance and appears in the cycle after it.
// Throughput is one transaction per clock: the output register frees up in
// the same cycle it is taken, so input stall is only raised while a result
// is held and the receiver stalls.
// Reset (synchronous, active low) loads the post-boot register values
// (AF=01B0, BC=0013, DE=00D8, HL=014D, SP=FFFE, PC=0100) and the start phase;
// the first transaction then yields the opcode fetch at 0100.
// Unknown opcodes, HALT included, run as no-ops and are flagged.
module cpu_load_instruction_sequencer
    import clis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_read_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_bus_address,
    output logic        o_bus_write,
    output logic [7:0]  o_write_data,
    output logic        o_opcode_fetch,
    output logic [4:0]  o_instr_cycles,
    output logic        o_unknown_opcode
);
`include "assert_macros.svh"

    t_phase      r_phase, n_phase;
    logic [7:0]  r_a, r_f, r_b, r_c, r_d, r_e, r_h, r_l;
    logic [7:0]  n_a, n_f, n_b, n_c, n_d, n_e, n_h, n_l;
    logic [15:0] r_sp, n_sp, r_pc, n_pc;
    logic [7:0]  r_op, n_op, r_imm, n_imm;
    logic        r_valid;
    logic [15:0] r_addr, n_addr;
    logic        r_wr, n_wr, r_fetch, n_fetch, r_unk, n_unk;
    logic [7:0]  r_wdata, n_wdata;
    logic [4:0]  r_cyc, n_cyc;

    logic        in_acc;
    logic [7:0]  rd, src_val;
    logic [15:0] hl, hl_inc, hl_dec, imm16, sp_sum;
    logic [4:0]  lo_sum;
    logic [8:0]  byte_sum;

    assign o_stall = r_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;
    assign rd      = i_read_data;
    assign hl      = {r_h, r_l};
    assign hl_inc  = hl + 16'd1;
    assign hl_dec  = hl - 16'd1;
    assign imm16   = {rd, r_imm};
    assign sp_sum  = r_sp + {{8{rd[7]}}, rd};
    assign lo_sum  = {1'b0, r_sp[3:0]} + {1'b0, rd[3:0]};
    assign byte_sum = {1'b0, r_sp[7:0]} + {1'b0, rd};

    // Source register of the LD r,r' and store groups
    always_comb begin
        case (rd[2:0])
            R_B: src_val = r_b;
            R_C: src_val = r_c;
            R_D: src_val = r_d;
            R_E: src_val = r_e;
            R_H: src_val = r_h;
            R_L: src_val = r_l;
            R_A: src_val = r_a;
            default: src_val = 8'h00;
        endcase
    end

    // Sequencer: one bus request per completed bus cycle
    always_comb begin
        logic [2:0]  dsel;
        logic [7:0]  dval;
        logic        dset;
        logic        fetch;
        logic [4:0]  fcyc;
        logic        funk;
        dsel = 3'd0; dval = 8'h00; dset = 1'b0;
        fetch = 1'b0; fcyc = 5'd0; funk = 1'b0;
        n_phase = r_phase;
        n_a = r_a; n_f = r_f; n_b = r_b; n_c = r_c;
        n_d = r_d; n_e = r_e; n_h = r_h; n_l = r_l;
        n_sp = r_sp; n_pc = r_pc; n_op = r_op; n_imm = r_imm;
        n_addr = 16'h0000; n_wr = 1'b0; n_wdata = 8'h00;

        case (r_phase)
            PH_OPCODE: begin
                n_op = rd;
                if (is_ldrr(rd)) begin
                    if (rd[5:3] == R_M) begin
                        n_addr = hl; n_wr = 1'b1; n_wdata = src_val;
                        n_phase = PH_WDONE;
                    end else if (rd[2:0] == R_M) begin
                        n_addr = hl; n_phase = PH_MEMREAD;
                    end else begin
                        dset = 1'b1; dsel = rd[5:3]; dval = src_val;
                        fetch = 1'b1; fcyc = 5'd4;
                    end
                end else if (is_ldrn(rd)) begin
                    n_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = PH_IMM1;
                end else begin
                    case (rd)
                        OP_NOP: begin fetch = 1'b1; fcyc = 5'd4; end
                        OP_LDH_NA, OP_LDH_AN, OP_LD_HLSP, OP_LD_BCNN, OP_LD_DENN,
                        OP_LD_HLNN, OP_LD_SPNN, OP_LD_ANN, OP_LD_NNA: begin
                            n_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = PH_IMM1;
                        end
                        OP_LD_ABC: begin n_addr = {r_b, r_c}; n_phase = PH_MEMREAD; end
                        OP_LD_ADE: begin n_addr = {r_d, r_e}; n_phase = PH_MEMREAD; end
                        OP_LD_AHLI: begin
                            n_addr = hl; n_phase = PH_MEMREAD;
                            {n_h, n_l} = hl_inc;
                        end
                        OP_LD_AHLD: begin
                            n_addr = hl; n_phase = PH_MEMREAD;
                            {n_h, n_l} = hl_dec;
                        end
                        OP_LDH_AC: begin
                            n_addr = HIGH_PAGE | {8'h00, r_c}; n_phase = PH_MEMREAD;
                        end
                        OP_LD_BCA: begin
                            n_addr = {r_b, r_c}; n_wr = 1'b1; n_wdata = r_a;
                            n_phase = PH_WDONE;
                        end
                        OP_LD_DEA: begin
                            n_addr = {r_d, r_e}; n_wr = 1'b1; n_wdata = r_a;
                            n_phase = PH_WDONE;
                        end
                        OP_LD_HLIA: begin
                            n_addr = hl; n_wr = 1'b1; n_wdata = r_a;
                            n_phase = PH_WDONE; {n_h, n_l} = hl_inc;
                        end
                        OP_LD_HLDA: begin
                            n_addr = hl; n_wr = 1'b1; n_wdata = r_a;
                            n_phase = PH_WDONE; {n_h, n_l} = hl_dec;
                        end
                        OP_LDH_CA: begin
                            n_addr = HIGH_PAGE | {8'h00, r_c}; n_wr = 1'b1;
                            n_wdata = r_a; n_phase = PH_WDONE;
                        end
                        OP_LD_SPHL: begin n_sp = hl; fetch = 1'b1; fcyc = 5'd8; end
                        default: begin fetch = 1'b1; fcyc = 5'd4; funk = 1'b1; end
                    endcase
                end
            end
            PH_IMM1: begin
                if (is_ldrn(r_op) && r_op != OP_LD_HLN) begin
                    dset = 1'b1; dsel = r_op[5:3]; dval = rd;
                    fetch = 1'b1; fcyc = 5'd8;
                end else begin
                    case (r_op)
                        OP_LD_HLN: begin
                            n_addr = hl; n_wr = 1'b1; n_wdata = rd; n_phase = PH_WDONE;
                        end
                        OP_LDH_NA: begin
                            n_addr = HIGH_PAGE | {8'h00, rd}; n_wr = 1'b1;
                            n_wdata = r_a; n_phase = PH_WDONE;
                        end
                        OP_LDH_AN: begin
                            n_addr = HIGH_PAGE | {8'h00, rd}; n_phase = PH_MEMREAD;
                        end
                        OP_LD_HLSP: begin
                            n_f = {2'b00, lo_sum[4], byte_sum[8], 4'h0};
                            {n_h, n_l} = sp_sum;
                            fetch = 1'b1; fcyc = 5'd12;
                        end
                        OP_LD_BCNN, OP_LD_DENN, OP_LD_HLNN, OP_LD_SPNN,
                        OP_LD_ANN, OP_LD_NNA: begin
                            n_imm = rd; n_addr = r_pc; n_pc = r_pc + 16'd1;
                            n_phase = PH_IMM2;
                        end
                        default: begin fetch = 1'b1; fcyc = cycles_of(r_op); end
                    endcase
                end
            end
            PH_IMM2: begin
                case (r_op)
                    OP_LD_BCNN: begin n_b = rd; n_c = r_imm; fetch = 1'b1; fcyc = 5'd12; end
                    OP_LD_DENN: begin n_d = rd; n_e = r_imm; fetch = 1'b1; fcyc = 5'd12; end
                    OP_LD_HLNN: begin n_h = rd; n_l = r_imm; fetch = 1'b1; fcyc = 5'd12; end
                    OP_LD_SPNN: begin n_sp = imm16; fetch = 1'b1; fcyc = 5'd12; end
                    OP_LD_ANN: begin n_addr = imm16; n_phase = PH_MEMREAD; end
                    OP_LD_NNA: begin
                        n_addr = imm16; n_wr = 1'b1; n_wdata = r_a; n_phase = PH_WDONE;
                    end
                    default: begin fetch = 1'b1; fcyc = cycles_of(r_op); end
                endcase
            end
            PH_MEMREAD: begin
                dset = 1'b1;
                dsel = (r_op[7:6] == 2'b01) ? r_op[5:3] : R_A;
                dval = rd;
                fetch = 1'b1; fcyc = cycles_of(r_op);
            end
            PH_WDONE: begin fetch = 1'b1; fcyc = cycles_of(r_op); end
            default: begin fetch = 1'b1; fcyc = 5'd0; end
        endcase

        // Register write-back for the 8-bit destinations
        if (dset) begin
            case (dsel)
                R_B: n_b = dval;
                R_C: n_c = dval;
                R_D: n_d = dval;
                R_E: n_e = dval;
                R_H: n_h = dval;
                R_L: n_l = dval;
                R_A: n_a = dval;
                default: ;
            endcase
        end

        // Opcode fetch from PC closes the instruction
        if (fetch) begin
            n_addr = r_pc; n_wr = 1'b0; n_wdata = 8'h00;
            n_pc = r_pc + 16'd1; n_phase = PH_OPCODE;
        end
        n_fetch = fetch;
        n_cyc = fetch ? fcyc : 5'd0;
        n_unk = fetch && funk;
    end

    // Architectural state and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_a <= 8'h01; r_f <= 8'hB0; r_b <= 8'h00; r_c <= 8'h13;
            r_d <= 8'h00; r_e <= 8'hD8; r_h <= 8'h01; r_l <= 8'h4D;
            r_sp <= 16'hFFFE; r_pc <= 16'h0100;
            r_op <= 8'h00; r_imm <= 8'h00;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_a <= n_a; r_f <= n_f; r_b <= n_b; r_c <= n_c;
            r_d <= n_d; r_e <= n_e; r_h <= n_h; r_l <= n_l;
            r_sp <= n_sp; r_pc <= n_pc;
            r_op <= n_op; r_imm <= n_imm;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_acc) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr <= n_addr; r_wr <= n_wr; r_wdata <= n_wdata;
            r_fetch <= n_fetch; r_cyc <= n_cyc; r_unk <= n_unk;
        end
    end

    assign o_valid          = r_valid;
    assign o_bus_address    = r_addr;
    assign o_bus_write      = r_wr;
    assign o_write_data     = r_wdata;
    assign o_opcode_fetch   = r_fetch;
    assign o_instr_cycles   = r_cyc;
    assign o_unknown_opcode = r_unk;

    `ASSERT_IMPL(a_phase_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_phase))
    `ASSERT_IMPL(a_wr_not_fetch, i_clk, i_rst_n, r_valid, !(r_wr && r_fetch))
    `ASSERT_IMPL(a_cyc_only_fetch, i_clk, i_rst_n, r_valid && !r_fetch,
        r_cyc == 5'd0 && !r_unk)
    `ASSERT_NEXT(a_write_then_wdone, i_clk, i_rst_n, in_acc && n_wr,
        r_phase == PH_WDONE)
    `ASSERT_NEXT(a_fetch_then_opcode, i_clk, i_rst_n, in_acc && n_fetch,
        r_phase == PH_OPCODE)
endmodule

// File: sim/cpu_load_instruction_sequencer_checker.sv
// Checker: predicts each bus request of the load sequencer and compares it with the block
module cpu_load_instruction_sequencer_checker
    import clis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [7:0]  i_read_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_bus_address,
    input  logic        i_bus_write,
    input  logic [7:0]  i_write_data,
    input  logic        i_opcode_fetch,
    input  logic [4:0]  i_instr_cycles,
    input  logic        i_unknown_opcode,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] addr;
        logic        wr;
        logic [7:0]  wdata;
        logic        fetch;
        logic [4:0]  cyc;
        logic        unk;
    } t_bus_req;

    // Shadow CPU state
    logic [7:0]  cpu_a, cpu_f, cpu_b, cpu_c, cpu_d, cpu_e, cpu_h, cpu_l;
    logic [15:0] cpu_sp, cpu_pc;
    t_phase      cpu_phase;
    logic [7:0]  cur_op, imm_lo;
    t_bus_req    next_req;
    t_bus_req    req_queue[$];
    int          mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = req_queue.size();

    function automatic logic [4:0] instr_len(input logic [7:0] op);
        if (op[7:6] == 2'b01 && op != OP_HALT)
            return (op[2:0] == R_M || op[5:3] == R_M) ? 5'd8 : 5'd4;
        if ((op & 8'hC7) == 8'h06)
            return (op == OP_LD_HLN) ? 5'd12 : 5'd8;
        case (op)
            OP_LD_ABC, OP_LD_ADE, OP_LD_AHLI, OP_LD_AHLD, OP_LD_BCA, OP_LD_DEA,
            OP_LD_HLIA, OP_LD_HLDA, OP_LDH_CA, OP_LDH_AC, OP_LD_SPHL: return 5'd8;
            OP_LD_ANN, OP_LD_NNA: return 5'd16;
            OP_LDH_NA, OP_LDH_AN, OP_LD_HLSP,
            OP_LD_BCNN, OP_LD_DENN, OP_LD_HLNN, OP_LD_SPNN: return 5'd12;
            default: return 5'd4;
        endcase
    endfunction

    function automatic logic [7:0] reg_read(input logic [2:0] idx);
        case (idx)
            R_B: return cpu_b;
            R_C: return cpu_c;
            R_D: return cpu_d;
            R_E: return cpu_e;
            R_H: return cpu_h;
            R_L: return cpu_l;
            R_A: return cpu_a;
            default: return 8'h00;
        endcase
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [7:0] v);
        case (idx)
            R_B: cpu_b = v;
            R_C: cpu_c = v;
            R_D: cpu_d = v;
            R_E: cpu_e = v;
            R_H: cpu_h = v;
            R_L: cpu_l = v;
            R_A: cpu_a = v;
            default: ;
        endcase
    endtask

    task automatic set_hl(input logic [15:0] v);
        cpu_h = v[15:8];
        cpu_l = v[7:0];
    endtask

    task automatic issue_fetch(input logic [4:0] cyc, input logic unk);
        next_req = '{addr: cpu_pc, wr: 1'b0, wdata: 8'h00, fetch: 1'b1, cyc: cyc, unk: unk};
        cpu_pc = cpu_pc + 16'd1;
        cpu_phase = PH_OPCODE;
    endtask

    task automatic issue_read(input logic [15:0] addr, input t_phase nxt);
        next_req = '{addr: addr, wr: 1'b0, wdata: 8'h00, fetch: 1'b0, cyc: 5'd0, unk: 1'b0};
        cpu_phase = nxt;
    endtask

    task automatic issue_pc_read(input t_phase nxt);
        issue_read(cpu_pc, nxt);
        cpu_pc = cpu_pc + 16'd1;
    endtask

    task automatic issue_write(input logic [15:0] addr, input logic [7:0] v);
        next_req = '{addr: addr, wr: 1'b1, wdata: v, fetch: 1'b0, cyc: 5'd0, unk: 1'b0};
        cpu_phase = PH_WDONE;
    endtask

    // Decode of a freshly fetched opcode
    task automatic run_opcode(input logic [7:0] op);
        logic [15:0] hl;
        hl = {cpu_h, cpu_l};
        cur_op = op;
        if (op[7:6] == 2'b01 && op != OP_HALT) begin
            if (op[5:3] == R_M) issue_write(hl, reg_read(op[2:0]));
            else if (op[2:0] == R_M) issue_read(hl, PH_MEMREAD);
            else begin
                reg_write(op[5:3], reg_read(op[2:0]));
                issue_fetch(5'd4, 1'b0);
            end
        end else if ((op & 8'hC7) == 8'h06) begin
            issue_pc_read(PH_IMM1);
        end else begin
            case (op)
                OP_NOP: issue_fetch(5'd4, 1'b0);
                OP_LDH_NA, OP_LDH_AN, OP_LD_HLSP, OP_LD_BCNN, OP_LD_DENN,
                OP_LD_HLNN, OP_LD_SPNN, OP_LD_ANN, OP_LD_NNA: issue_pc_read(PH_IMM1);
                OP_LD_ABC:  issue_read({cpu_b, cpu_c}, PH_MEMREAD);
                OP_LD_ADE:  issue_read({cpu_d, cpu_e}, PH_MEMREAD);
                OP_LD_AHLI: begin issue_read(hl, PH_MEMREAD); set_hl(hl + 16'd1); end
                OP_LD_AHLD: begin issue_read(hl, PH_MEMREAD); set_hl(hl - 16'd1); end
                OP_LDH_AC:  issue_read(HIGH_PAGE | {8'h00, cpu_c}, PH_MEMREAD);
                OP_LD_BCA:  issue_write({cpu_b, cpu_c}, cpu_a);
                OP_LD_DEA:  issue_write({cpu_d, cpu_e}, cpu_a);
                OP_LD_HLIA: begin issue_write(hl, cpu_a); set_hl(hl + 16'd1); end
                OP_LD_HLDA: begin issue_write(hl, cpu_a); set_hl(hl - 16'd1); end
                OP_LDH_CA:  issue_write(HIGH_PAGE | {8'h00, cpu_c}, cpu_a);
                OP_LD_SPHL: begin cpu_sp = hl; issue_fetch(5'd8, 1'b0); end
                default:    issue_fetch(5'd4, 1'b1);
            endcase
        end
    endtask

    // First immediate byte
    task automatic run_imm1(input logic [7:0] rd);
        logic [15:0] sum;
        logic        hf, cf;
        if ((cur_op & 8'hC7) == 8'h06 && cur_op != OP_LD_HLN) begin
            reg_write(cur_op[5:3], rd);
            issue_fetch(5'd8, 1'b0);
        end else begin
            case (cur_op)
                OP_LD_HLN: issue_write({cpu_h, cpu_l}, rd);
                OP_LDH_NA: issue_write(HIGH_PAGE | {8'h00, rd}, cpu_a);
                OP_LDH_AN: issue_read(HIGH_PAGE | {8'h00, rd}, PH_MEMREAD);
                OP_LD_HLSP: begin
                    sum = cpu_sp + {{8{rd[7]}}, rd};
                    hf = ({1'b0, cpu_sp[3:0]} + {1'b0, rd[3:0]}) > 5'h0F;
                    cf = ({1'b0, cpu_sp[7:0]} + {1'b0, rd}) > 9'h0FF;
                    cpu_f = {2'b00, hf, cf, 4'b0000};
                    set_hl(sum);
                    issue_fetch(5'd12, 1'b0);
                end
                OP_LD_BCNN, OP_LD_DENN, OP_LD_HLNN, OP_LD_SPNN, OP_LD_ANN, OP_LD_NNA: begin
                    imm_lo = rd;
                    issue_pc_read(PH_IMM2);
                end
                default: issue_fetch(instr_len(cur_op), 1'b0);
            endcase
        end
    endtask

    // Second immediate byte
    task automatic run_imm2(input logic [7:0] rd);
        case (cur_op)
            OP_LD_BCNN: begin cpu_b = rd; cpu_c = imm_lo; issue_fetch(5'd12, 1'b0); end
            OP_LD_DENN: begin cpu_d = rd; cpu_e = imm_lo; issue_fetch(5'd12, 1'b0); end
            OP_LD_HLNN: begin set_hl({rd, imm_lo}); issue_fetch(5'd12, 1'b0); end
            OP_LD_SPNN: begin cpu_sp = {rd, imm_lo}; issue_fetch(5'd12, 1'b0); end
            OP_LD_ANN:  issue_read({rd, imm_lo}, PH_MEMREAD);
            OP_LD_NNA:  issue_write({rd, imm_lo}, cpu_a);
            default:    issue_fetch(instr_len(cur_op), 1'b0);
        endcase
    endtask

    task automatic step_cpu(input logic [7:0] rd);
        case (cpu_phase)
            PH_OPCODE: run_opcode(rd);
            PH_IMM1:   run_imm1(rd);
            PH_IMM2:   run_imm2(rd);
            PH_MEMREAD: begin
                if (cur_op[7:6] == 2'b01) reg_write(cur_op[5:3], rd);
                else cpu_a = rd;
                issue_fetch(instr_len(cur_op), 1'b0);
            end
            PH_WDONE: issue_fetch(instr_len(cur_op), 1'b0);
            default:  issue_fetch(5'd0, 1'b0);
        endcase
    endtask

    // Compare retired requests, then predict from accepted bus cycles
    always @(posedge i_clk) begin
        t_bus_req got, want;
        if (!i_rst_n) begin
            cpu_a = 8'h01; cpu_f = 8'hB0; cpu_b = 8'h00; cpu_c = 8'h13;
            cpu_d = 8'h00; cpu_e = 8'hD8; cpu_h = 8'h01; cpu_l = 8'h4D;
            cpu_sp = 16'hFFFE;
            cpu_pc = 16'h0100;
            cpu_phase = PH_START;
            cur_op = 8'h00;
            imm_lo = 8'h00;
            req_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{addr: i_bus_address, wr: i_bus_write, wdata: i_write_data,
                        fetch: i_opcode_fetch, cyc: i_instr_cycles, unk: i_unknown_opcode};
                if (req_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected request addr=%h wr=%b", got.addr, got.wr);
                end else begin
                    want = req_queue.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: expected addr=%h wr=%b wd=%h fetch=%b ",
                                      "cyc=%0d unk=%b, got addr=%h wr=%b wd=%h ",
                                      "fetch=%b cyc=%0d unk=%b"},
                                     want.addr, want.wr, want.wdata, want.fetch, want.cyc,
                                     want.unk, got.addr, got.wr, got.wdata, got.fetch,
                                     got.cyc, got.unk);
                    end
                end
            end
            if (i_valid && !i_stall_in) begin
                step_cpu(i_read_data);
                req_queue.push_back(next_req);
            end
        end
    end

    initial mismatches = 0;
endmodule

// File: sim/cpu_load_instruction_sequencer_tb.sv
// Testbench top: drives bus-cycle transactions and stalls, and gives the verdict
module cpu_load_instruction_sequencer_tb;
    import clis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [7:0]  i_read_data = 8'h00;
    logic        o_stall, o_valid, o_bus_write, o_opcode_fetch, o_unknown_opcode;
    logic [15:0] o_bus_address;
    logic [7:0]  o_write_data;
    logic [4:0]  o_instr_cycles;
    int          fail_count, pending;
    int          rx_cycle = 0;

    localparam logic [7:0] OTHER_OPS [0:17] = '{
        OP_NOP, OP_LD_ABC, OP_LD_ADE, OP_LD_AHLI, OP_LD_AHLD, OP_LD_BCA, OP_LD_DEA,
        OP_LD_HLIA, OP_LD_HLDA, OP_LDH_CA, OP_LDH_AC, OP_LD_SPHL, OP_LD_ANN,
        OP_LD_NNA, OP_LDH_NA, OP_LDH_AN, OP_LD_HLSP, OP_LD_HLNN};

    // Directed bytes: the first is ignored, then opcodes with their operands
    localparam logic [7:0] DIRECTED [0:24] = '{
        8'hA5, OP_NOP, OP_HALT, 8'h45, 8'hCB, OP_LD_HLSP, 8'hFF, OP_LD_HLSP, 8'h01,
        OP_LD_HLNN, 8'h00, 8'h00, OP_LD_AHLD, 8'h80, OP_LD_HLIA, 8'h00, OP_LD_HLN,
        8'hFF, 8'h00, OP_LD_NNA, 8'h34, 8'h12, 8'h00, OP_LDH_AN, 8'h7F};

    always #4 i_clk = ~i_clk;

    cpu_load_instruction_sequencer dut (.*);

    cpu_load_instruction_sequencer_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_read_data(i_read_data), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_bus_address(o_bus_address), .i_bus_write(o_bus_write),
        .i_write_data(o_write_data), .i_opcode_fetch(o_opcode_fetch),
        .i_instr_cycles(o_instr_cycles), .i_unknown_opcode(o_unknown_opcode),
        .o_fail_count(fail_count), .o_pending(pending));

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly load opcodes so instructions run to completion; some raw noise
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 8'h40 | 8'($urandom_range(0, 63));
        if (r == 4) return 8'(($urandom_range(0, 7) << 3) | 6);
        if (r < 8) return OTHER_OPS[$urandom_range(0, 17)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_cycle(input logic [7:0] v, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_read_data <= v;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Wait until every predicted result has been taken
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver stall pattern with one long hold-off
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (rx_cycle == 1000) begin
                i_stall <= 1'b1;
                repeat (120) @(posedge i_clk);
            end else if ((rx_cycle / 400) % 3 == 0) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < 2) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(10, 30)) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 99) < 25);
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (DIRECTED[k]) send_cycle(DIRECTED[k], 0);
        for (int n = 0; n < 1450; n++) begin
            if (n == 700) begin
                i_valid <= 1'b0;
                drain();
                send_cycle(pick_byte(), 0);
            end else begin
                send_cycle(pick_byte(), pick_gap());
            end
        end
        i_valid <= 1'b0;
        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("PASS cpu_load_instruction_sequencer");
        else $display("FAIL cpu_load_instruction_sequencer");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL cpu_load_instruction_sequencer");
        $finish;
    end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/clis_pkg.sv
hw/rtl/cpu_load_instruction_sequencer.sv
sim/cpu_load_instruction_sequencer_checker.sv
sim/cpu_load_instruction_sequencer_tb.sv
